FILE: rtl/core/ffpd_pkg.sv
package ffpd_pkg;

  // Character codes used by the form scanner
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2D;

  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned KeyLenW    = 4;
  localparam int unsigned ResPerItem = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [8*KeyBytes-1:0] SearchKeyRst = 64'h0000_0000_6469_7373;
  localparam logic [KeyLenW-1:0]    KeyLengthRst = 4'd4;
  localparam logic [7:0]            ValueLimitRst = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEARCH_KEY  = 2'd0,
    REG_KEY_LENGTH  = 2'd1,
    REG_VALUE_LIMIT = 2'd2
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PH_MATCH = 6'b000001,
    PH_SKIP  = 6'b000010,
    PH_VALUE = 6'b000100,
    PH_ESC1  = 6'b001000,
    PH_ESC2  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [8*KeyBytes-1:0] search_key;
    logic [KeyLenW-1:0]    key_length;
    logic [7:0]            value_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       end_marker;
    logic       key_found;
  } result_t;

  // Results caused by one body byte, res[0] goes out first
  typedef struct packed {
    logic [1:0]               count;
    result_t [ResPerItem-1:0] res;
  } record_t;

endpackage

FILE: rtl/core/ffpd_if.sv
interface ffpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_last;
  modport source (output valid, body_byte, body_last, input ready);
  modport sink   (input valid, body_byte, body_last, output ready);
endinterface

interface ffpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       end_marker;
  logic       key_found;
  modport source (output valid, value_byte, end_marker, key_found, input ready);
  modport sink   (input valid, value_byte, end_marker, key_found, output ready);
endinterface

interface ffpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/form_field_percent_decoder_unit.sv
// Form field extractor: scans a url-encoded form body one byte per item and
// streams out the percent-decoded value of the field whose name matches
// search_key (key_length bytes, first character in the low byte) and is
// followed by '='; names match only at body start or after '&'. Each body
// ends with exactly one end-marker item telling whether the key was found;
// a zero byte or body_last ends the body, and body_last also rearms the
// scanner. Rate: one body byte is accepted every cycle while the 4-record
// queue between the scanner and the output stage has room; the output
// stage sends one result per cycle while the receiver is ready, and a byte
// that ends a body inside an escape yields up to three results. An accepted
// byte's first result passes through the record queue and then the output
// register. Configuration writes are always accepted and take effect on the
// next byte; write only while the block is idle.
module form_field_percent_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffpd_in_if.sink    in_i,
  ffpd_cfg_if.sink   cfg_i,
  ffpd_out_if.source out_o
);

  ffpd_pkg::cfg_t    cfg_q;
  ffpd_pkg::record_t push_rec, head_rec;
  logic              push, full, pop, head_valid;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.search_key  <= ffpd_pkg::SearchKeyRst;
      cfg_q.key_length  <= ffpd_pkg::KeyLengthRst;
      cfg_q.value_limit <= ffpd_pkg::ValueLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ffpd_pkg::REG_SEARCH_KEY:  cfg_q.search_key  <= cfg_i.data;
        ffpd_pkg::REG_KEY_LENGTH:  cfg_q.key_length  <= cfg_i.data[ffpd_pkg::KeyLenW-1:0];
        ffpd_pkg::REG_VALUE_LIMIT: cfg_q.value_limit <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // Front: key match and decode, one record of results per byte that yields any
  ffpd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .rec_o  (push_rec)
  );

  ffpd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_rec_i   (push_rec),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_rec_o   (head_rec)
  );

  // Back: serializes each record onto the output register
  ffpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_rec_i   (head_rec),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  // Records are only pushed into a queue with room
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("push into full queue");

  // Queued records always carry at least one result
  a_rec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> head_rec.count != 2'd0) else $error("empty record queued");

  // End markers carry a zero byte; value bytes never flag found
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_marker |-> out_o.value_byte == 8'd0)
    else $error("end marker with nonzero byte");

  a_found_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.end_marker |-> !out_o.key_found)
    else $error("key_found on value byte");

endmodule

FILE: rtl/core/ffpd_front.sv
module ffpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ffpd_in_if.sink             in_i,
  input  ffpd_pkg::cfg_t      cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output ffpd_pkg::record_t   rec_o
);

  typedef struct packed {
    ffpd_pkg::phase_e                       ph;
    logic [7:0]                             ec;
    logic [1:0]                             n;
    ffpd_pkg::result_t [ffpd_pkg::ResPerItem-1:0] res;
  } step_t;

  function automatic logic [4:0] f_hex(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] f_decode(logic [7:0] a, logic [7:0] b);
    logic [4:0] va;
    logic [4:0] vb;
    logic [7:0] r;
    va = f_hex(a);
    vb = f_hex(b);
    if (a == ffpd_pkg::CharSpace || (a >= 8'd9 && a <= 8'd13)) begin
      r = vb[4] ? {4'd0, vb[3:0]} : 8'd0;
    end else if (a == ffpd_pkg::CharPlus || a == ffpd_pkg::CharMinus) begin
      if (!vb[4]) r = 8'd0;
      else if (a == ffpd_pkg::CharMinus) r = 8'd0 - {4'd0, vb[3:0]};
      else r = {4'd0, vb[3:0]};
    end else if (!va[4]) begin
      r = 8'd0;
    end else if (!vb[4]) begin
      r = {4'd0, va[3:0]};
    end else begin
      r = {va[3:0], vb[3:0]};
    end
    return r;
  endfunction

  function automatic step_t f_push(step_t s, logic [7:0] vb, logic em, logic kf);
    step_t r;
    r = s;
    r.res[r.n] = '{value_byte: vb, end_marker: em, key_found: kf};
    r.n = r.n + 2'd1;
    return r;
  endfunction

  function automatic step_t f_finish(step_t s, logic found);
    step_t r;
    r = f_push(s, 8'd0, 1'b1, found);
    r.ph = ffpd_pkg::PH_DONE;
    return r;
  endfunction

  function automatic step_t f_emit(step_t s, logic [7:0] c, logic [7:0] lim);
    step_t r;
    r = f_push(s, c, 1'b0, 1'b0);
    r.ec = r.ec + 8'd1;
    if (r.ec >= lim) r = f_finish(r, 1'b1);
    return r;
  endfunction

  function automatic step_t f_value_in(step_t s, logic [7:0] c, logic [7:0] lim);
    step_t r;
    r = s;
    if (s.ec >= lim || c == ffpd_pkg::CharAmp) r = f_finish(s, 1'b1);
    else if (c == ffpd_pkg::CharPlus) r = f_emit(s, ffpd_pkg::CharSpace, lim);
    else if (c == ffpd_pkg::CharPct) r.ph = ffpd_pkg::PH_ESC1;
    else r = f_emit(s, c, lim);
    return r;
  endfunction

  ffpd_pkg::phase_e ph_q, ph_d;
  logic [3:0]       kp_q, kp_d;
  logic [7:0]       ef_q, ef_d;
  logic [7:0]       ec_q, ec_d;
  logic             accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  always_comb begin
    step_t      s;
    logic [7:0] c;
    logic [7:0] lim;
    logic [3:0] klen;
    logic [7:0] k;
    c    = in_i.body_byte;
    lim  = cfg_i.value_limit;
    klen = (cfg_i.key_length > 4'(ffpd_pkg::KeyBytes)) ? 4'(ffpd_pkg::KeyBytes)
                                                        : cfg_i.key_length;
    k    = cfg_i.search_key[{kp_q[2:0], 3'b000} +: 8];
    s    = '0;
    s.ph = ph_q;
    s.ec = ec_q;
    kp_d = kp_q;
    ef_d = ef_q;
    if (c != 8'd0) begin
      case (ph_q)
        ffpd_pkg::PH_MATCH: begin
          if (kp_q < klen) begin
            if (c == k && c != ffpd_pkg::CharAmp) kp_d = kp_q + 4'd1;
            else if (c == ffpd_pkg::CharAmp) kp_d = 4'd0;
            else s.ph = ffpd_pkg::PH_SKIP;
          end else if (c == ffpd_pkg::CharEq) begin
            s.ph = ffpd_pkg::PH_VALUE;
            s.ec = 8'd0;
            if (lim == 8'd0) s = f_finish(s, 1'b1);
          end else if (c == ffpd_pkg::CharAmp) begin
            kp_d = 4'd0;
          end else begin
            s.ph = ffpd_pkg::PH_SKIP;
          end
        end
        ffpd_pkg::PH_SKIP: begin
          if (c == ffpd_pkg::CharAmp) begin
            s.ph = ffpd_pkg::PH_MATCH;
            kp_d = 4'd0;
          end
        end
        ffpd_pkg::PH_VALUE: s = f_value_in(s, c, lim);
        ffpd_pkg::PH_ESC1: begin
          ef_d = c;
          s.ph = ffpd_pkg::PH_ESC2;
        end
        ffpd_pkg::PH_ESC2: begin
          s.ph = ffpd_pkg::PH_VALUE;
          s = f_emit(s, f_decode(ef_q, c), lim);
        end
        default: ;
      endcase
    end
    // body end: zero byte or last flag
    if (c == 8'd0 || in_i.body_last) begin
      case (s.ph)
        ffpd_pkg::PH_MATCH, ffpd_pkg::PH_SKIP: s = f_finish(s, 1'b0);
        ffpd_pkg::PH_VALUE: s = f_finish(s, 1'b1);
        ffpd_pkg::PH_ESC1: begin
          s.ph = ffpd_pkg::PH_VALUE;
          s = f_emit(s, ffpd_pkg::CharPct, lim);
          if (s.ph != ffpd_pkg::PH_DONE) s = f_finish(s, 1'b1);
        end
        ffpd_pkg::PH_ESC2: begin
          // dangling '%' plus one byte: '%' goes out as a plain value byte, the held byte is scanned as value data
          s.ph = ffpd_pkg::PH_VALUE;
          s = f_emit(s, ffpd_pkg::CharPct, lim);
          if (s.ph == ffpd_pkg::PH_VALUE) s = f_value_in(s, ef_d, lim);
          if (s.ph == ffpd_pkg::PH_ESC1) s = f_emit(s, ffpd_pkg::CharPct, lim);
          if (s.ph != ffpd_pkg::PH_DONE) s = f_finish(s, 1'b1);
        end
        default: ;
      endcase
    end
    ph_d = s.ph;
    ec_d = s.ec;
    if (in_i.body_last) begin
      ph_d = ffpd_pkg::PH_MATCH;
      kp_d = 4'd0;
      ef_d = 8'd0;
      ec_d = 8'd0;
    end
    rec_o.count = s.n;
    rec_o.res   = s.res;
  end

  assign push_o = accept && (rec_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= ffpd_pkg::PH_MATCH;
      kp_q <= 4'd0;
      ef_q <= 8'd0;
      ec_q <= 8'd0;
    end else if (accept) begin
      ph_q <= ph_d;
      kp_q <= kp_d;
      ef_q <= ef_d;
      ec_q <= ec_d;
    end
  end

endmodule

FILE: rtl/core/ffpd_fifo.sv
module ffpd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ffpd_pkg::record_t push_rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output ffpd_pkg::record_t head_rec_o
);

  ffpd_pkg::record_t                 mem_q [ffpd_pkg::FifoDepth];
  logic [ffpd_pkg::FifoPtrW-1:0]     wr_q, rd_q;
  logic [ffpd_pkg::FifoPtrW:0]       cnt_q, cnt_d;

  assign full_o       = (cnt_q == (ffpd_pkg::FifoPtrW + 1)'(ffpd_pkg::FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_rec_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && head_valid_o)) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i && head_valid_o) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i && head_valid_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/ffpd_back.sv
module ffpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ffpd_pkg::record_t head_rec_i,
  output logic              pop_o,
  ffpd_out_if.source        out_o
);

  logic              out_valid_q, out_valid_d;
  ffpd_pkg::result_t out_res_q, out_res_d;
  logic [1:0]        idx_q, idx_d;
  logic              load, take, last_res;

  assign load     = !out_valid_q || out_o.ready;
  assign take     = load && head_valid_i;
  assign last_res = (idx_q == head_rec_i.count - 2'd1);
  assign pop_o    = take && last_res;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    idx_d       = idx_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_res_d   = head_rec_i.res[idx_q];
      idx_d       = last_res ? 2'd0 : idx_q + 2'd1;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.value_byte = out_res_q.value_byte;
  assign out_o.end_marker = out_res_q.end_marker;
  assign out_o.key_found  = out_res_q.key_found;

endmodule

FILE: sim/ffpd_checker.sv
`timescale 1ns / 100ps

// Scoreboard for the form field decoder: mirrors the scanner on every accepted
// body byte and compares each output item against the oldest prediction.
module ffpd_checker
  import ffpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ffpd_in_if          in_i,
  ffpd_cfg_if         cfg_i,
  ffpd_out_if         out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o,
  output int unsigned found_count_o,
  output int unsigned missing_count_o
);

  localparam logic [7:0] BodyEnd = 8'h00;
  localparam logic [7:0] BlankLo = 8'h09;
  localparam logic [7:0] BlankHi = 8'h0D;

  // register shadow
  logic [8*KeyBytes-1:0] match_key;
  logic [KeyLenW-1:0]    match_len;
  logic [7:0]            emit_limit;

  // scanner shadow
  phase_e     scan_phase;
  int         key_idx;
  logic [7:0] esc_hi;
  int         value_count;

  result_t decoded_results[$];

  function automatic void restart_scan();
    scan_phase  = PH_MATCH;
    key_idx     = 0;
    esc_hi      = 8'h00;
    value_count = 0;
  endfunction

  function automatic void push_result(logic [7:0] vb, logic em, logic kf);
    result_t r;
    r.value_byte = vb;
    r.end_marker = em;
    r.key_found  = kf;
    decoded_results.push_back(r);
  endfunction

  function automatic void end_search(logic found);
    push_result(8'h00, 1'b1, found);
    scan_phase = PH_DONE;
  endfunction

  function automatic void emit_byte(logic [7:0] c);
    push_result(c, 1'b0, 1'b0);
    value_count++;
    if (value_count >= emit_limit) end_search(1'b1);
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CharSpace || (c >= BlankLo && c <= BlankHi);
  endfunction

  // strtol base 16 on two chars, low byte kept
  function automatic logic [7:0] decode_escape(logic [7:0] a, logic [7:0] b);
    int hi, lo;
    lo = hex_value(b);
    if (is_blank(a)) return (lo < 0) ? 8'h00 : 8'(lo);
    if (a == CharPlus || a == CharMinus) begin
      if (lo < 0) return 8'h00;
      return (a == CharMinus) ? 8'(-lo) : 8'(lo);
    end
    hi = hex_value(a);
    if (hi < 0) return 8'h00;
    if (lo < 0) return 8'(hi);
    return 8'(hi * 16 + lo);
  endfunction

  function automatic void value_char(logic [7:0] c);
    if (value_count >= emit_limit || c == CharAmp) begin
      end_search(1'b1);
    end else if (c == CharPlus) begin
      emit_byte(CharSpace);
    end else if (c == CharPct) begin
      scan_phase = PH_ESC1;
    end else begin
      emit_byte(c);
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    int         eff_len;
    logic [7:0] k;
    eff_len = (match_len > KeyBytes) ? KeyBytes : match_len;
    case (scan_phase)
      PH_MATCH: begin
        if (key_idx < eff_len) begin
          k = match_key[8*key_idx +: 8];
          if (c == k && c != CharAmp) key_idx++;
          else if (c == CharAmp) key_idx = 0;
          else scan_phase = PH_SKIP;
        end else if (c == CharEq) begin
          scan_phase  = PH_VALUE;
          value_count = 0;
          if (emit_limit == 0) end_search(1'b1);
        end else if (c == CharAmp) begin
          key_idx = 0;
        end else begin
          scan_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (c == CharAmp) begin
          scan_phase = PH_MATCH;
          key_idx    = 0;
        end
      end
      PH_VALUE: value_char(c);
      PH_ESC1: begin
        esc_hi     = c;
        scan_phase = PH_ESC2;
      end
      PH_ESC2: begin
        scan_phase = PH_VALUE;
        emit_byte(decode_escape(esc_hi, c));
      end
      default: ;
    endcase
  endfunction

  // body end: a pending escape falls back to literal bytes
  function automatic void close_body();
    case (scan_phase)
      PH_MATCH, PH_SKIP: end_search(1'b0);
      PH_VALUE: end_search(1'b1);
      PH_ESC1: begin
        scan_phase = PH_VALUE;
        emit_byte(CharPct);
        if (scan_phase != PH_DONE) end_search(1'b1);
      end
      PH_ESC2: begin
        scan_phase = PH_VALUE;
        emit_byte(CharPct);
        if (scan_phase == PH_VALUE) value_char(esc_hi);
        if (scan_phase == PH_ESC1) emit_byte(CharPct);
        if (scan_phase != PH_DONE) end_search(1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic last);
    if (c == BodyEnd) begin
      close_body();
    end else begin
      scan_byte(c);
      if (last) close_body();
    end
    if (last) restart_scan();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      match_key  = SearchKeyRst;
      match_len  = KeyLengthRst;
      emit_limit = ValueLimitRst;
      restart_scan();
      decoded_results.delete();
      fail_count_o    = 0;
      result_count_o  = 0;
      found_count_o   = 0;
      missing_count_o = 0;
    end else begin
      // outputs first: nothing accepted this edge can already be out
      if (out_i.valid && out_i.ready) begin
        got.value_byte = out_i.value_byte;
        got.end_marker = out_i.end_marker;
        got.key_found  = out_i.key_found;
        if (decoded_results.size() == 0) begin
          $display("%0t: unexpected item: expected none, got value %02h end %b found %b",
                   $time, got.value_byte, got.end_marker, got.key_found);
          fail_count_o++;
        end else begin
          want = decoded_results.pop_front();
          if (got.value_byte !== want.value_byte || got.end_marker !== want.end_marker ||
              got.key_found !== want.key_found) begin
            $display("%0t: mismatch: expected value %02h end %b found %b, got value %02h end %b found %b",
                     $time, want.value_byte, want.end_marker, want.key_found,
                     got.value_byte, got.end_marker, got.key_found);
            fail_count_o++;
          end
          result_count_o++;
          if (want.end_marker) begin
            if (want.key_found) found_count_o++;
            else missing_count_o++;
          end
        end
      end
      if (in_i.valid && in_i.ready) predict_byte(in_i.body_byte, in_i.body_last);
      // a write lands after the byte of the same edge
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SEARCH_KEY:  match_key  = cfg_i.data;
          REG_KEY_LENGTH:  match_len  = cfg_i.data[KeyLenW-1:0];
          REG_VALUE_LIMIT: emit_limit = cfg_i.data[7:0];
          default: ;
        endcase
      end
    end
    pending_o = decoded_results.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import ffpd_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int TargetItems  = 480;
  localparam int HoldCycles   = 120;  // long receiver hold for back-pressure
  localparam int SettleCycles = 12;   // scanner + 4-deep record queue, with margin
  localparam logic [7:0] BodyEnd = 8'h00;

  logic clk = 1'b0;
  logic rst_n;

  ffpd_in_if  in_ch ();
  ffpd_cfg_if cfg_ch ();
  ffpd_out_if out_ch ();

  int unsigned fail_count, pending, result_count, found_count, missing_count;

  form_field_percent_decoder_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  ffpd_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_i            (in_ch),
    .cfg_i           (cfg_ch),
    .out_i           (out_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .result_count_o  (result_count),
    .found_count_o   (found_count),
    .missing_count_o (missing_count)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Stimulus bookkeeping
  logic [7:0]  body_q[$];    // bytes of the body being built
  logic [63:0] cur_key;      // key as last written
  int          cur_len;      // key length as the scanner uses it (capped at 8)
  int          bytes_sent;   // accepted bytes up to each body's zero terminator
  int          bodies_sent;
  int          settings_used;
  bit          hold_req = 1'b0;  // asks the receiver for one long hold

  // ---------------------------------------------------------------------------
  // Body builders
  // ---------------------------------------------------------------------------

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  // Key alphabet is tiny so random names often share a prefix with the key
  function automatic logic [7:0] rand_key_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return "a" + 8'($urandom_range(0, 3));
    if (r == 7) return 8'($urandom_range(1, 255));
    if (r == 8) return CharEq;
    return CharPct;
  endfunction

  // Characters after '%': hex digits, blanks, signs, junk, even '&' and '%'
  function automatic logic [7:0] esc_char();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0, 1, 2, 3: begin
        r = $urandom_range(0, 21);
        if (r < 10) return "0" + 8'(r);
        if (r < 16) return "a" + 8'(r - 10);
        return "A" + 8'(r - 16);
      end
      4:  return CharSpace;
      5:  return 8'($urandom_range(9, 13));
      6:  return CharPlus;
      7:  return CharMinus;
      8:  return CharAmp;
      9:  return "g";
      10: return CharPct;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void add_name();
    int r, start, pos;
    r = $urandom_range(0, 9);
    start = body_q.size();
    if (r <= 6) begin
      for (int i = 0; i < cur_len; i++) body_q.push_back(cur_key[8*i +: 8]);
      // near miss: one key char replaced, or the name cut short
      if (r >= 5 && cur_len > 0) begin
        pos = $urandom_range(0, cur_len - 1);
        if (r == 5) body_q[start + pos] = rand_key_char();
        else while (body_q.size() > start + pos) void'(body_q.pop_back());
      end
    end else if (r <= 8) begin
      repeat ($urandom_range(1, 3)) body_q.push_back("a" + 8'($urandom_range(0, 3)));
    end
  endfunction

  function automatic void add_value();
    int r, n;
    r = $urandom_range(0, 9);
    n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 6) : $urandom_range(7, 30);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 3) begin
        body_q.push_back(CharPlus);
      end else if (r < 6) begin
        body_q.push_back(CharPct);
        body_q.push_back(esc_char());
        body_q.push_back(esc_char());
      end else if (r == 6) begin
        body_q.push_back(CharEq);
      end else begin
        body_q.push_back(8'($urandom_range(1, 255)));
      end
    end
  endfunction

  // Mostly well-formed bodies of a few fields; about one in ten is raw noise
  function automatic void build_body();
    int r;
    body_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) body_q.push_back(CharAmp);
    for (int f = $urandom_range(1, 3); f > 0; f--) begin
      add_name();
      if ($urandom_range(0, 6) != 0) body_q.push_back(CharEq);
      else body_q.push_back(rand_key_char());
      add_value();
      if (f > 1) body_q.push_back(CharAmp);
    end
    // tail: body may end inside an escape, or at an explicit zero byte
    r = $urandom_range(0, 9);
    case (r)
      0: body_q.push_back(CharPct);
      1: begin
        body_q.push_back(CharPct);
        body_q.push_back(esc_char());
      end
      2: begin
        body_q.push_back(BodyEnd);
        repeat ($urandom_range(1, 2)) body_q.push_back(8'($urandom_range(0, 255)));
      end
      3: body_q.push_back(BodyEnd);
      default: ;
    endcase
    if (body_q.size() == 0) body_q.push_back(BodyEnd);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers (all entered and left right at a rising edge)
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 25);
    if (n > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.body_byte <= 8'($urandom_range(0, 255));
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.body_byte <= b;
    in_ch.body_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // valid stays up after the final byte; the next gap or settle drops it
  task automatic send_body(input bit no_gaps);
    bit ended;
    ended = 1'b0;
    for (int i = 0; i < body_q.size(); i++) begin
      if (!no_gaps) idle_gap();
      send_byte(body_q[i], i == body_q.size() - 1);
      if (!ended) bytes_sent++;   // bytes after a zero are ignored by the block
      if (body_q[i] == BodyEnd) ended = 1'b1;
    end
    bodies_sent++;
  endtask

  // Wait until every predicted item is out, then let no-result bytes drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Register settings: first a fixed list of corner settings, then random ones.
  // Unused upper bits of every write are random, but for the all-ones key.
  task automatic apply_setting(input int p);
    logic [63:0] key;
    int          klen, r;
    logic [7:0]  limit;
    key = {$urandom, $urandom};
    case (p)
      0: begin                        // directed part: key "a"
        klen = 1;
        limit = 8'd32;
        key[7:0] = "a";
      end
      1: begin                        // empty key: field starting with '='
        klen = 0;
        limit = 8'd5;
      end
      2: begin                        // longest key, largest limit
        klen = 8;
        limit = 8'd255;
        for (int i = 0; i < 8; i++) key[8*i +: 8] = $urandom_range(0, 1) ? "a" : "b";
      end
      3: begin                        // oversized key length, zero limit
        klen = 15;
        limit = 8'd0;
        for (int i = 0; i < 8; i++) key[8*i +: 8] = rand_key_char();
      end
      4: begin                        // '&' inside the key: never found
        klen = 3;
        limit = 8'd1;
        key[23:0] = {8'("b"), CharAmp, 8'("a")};
      end
      5: begin                        // all-ones key
        key = '1;
        klen = 2;
        limit = 8'd3;
      end
      default: begin
        r = $urandom_range(0, 9);
        klen = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) :
               (r == 2) ? 8 : $urandom_range(1, 4);
        for (int i = 0; i < 8; i++) if (i < klen) key[8*i +: 8] = rand_key_char();
        r = $urandom_range(0, 9);
        limit = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 :
                (r < 7) ? 8'($urandom_range(2, 8)) : 8'($urandom_range(9, 40));
      end
    endcase
    write_reg(REG_SEARCH_KEY, key);
    write_reg(REG_KEY_LENGTH, {$urandom, 28'($urandom), 4'(klen)});
    write_reg(REG_VALUE_LIMIT, {$urandom, 24'($urandom), limit});
    cur_key = key;
    cur_len = (klen > KeyBytes) ? KeyBytes : klen;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: runs of ready, runs of stall, per-cycle coin flips, and one long
  // hold on request while the sender keeps pushing.
  // ---------------------------------------------------------------------------
  initial begin
    int   run_left, r;
    logic level;
    run_left = 0;
    level = 1'b1;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            level = 1'b0;
            run_left = $urandom_range(8, 30);
          end else if (r < 3) begin
            level = 1'b1;
            run_left = $urandom_range(10, 40);
          end else begin
            level = ($urandom_range(0, 2) != 0);
            run_left = 1;
          end
        end
        out_ch.ready <= level;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int p, budget;
    in_ch.valid     = 1'b0;
    in_ch.body_byte = 8'h00;
    in_ch.body_last = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_SEARCH_KEY;
    cfg_ch.data     = '0;
    bytes_sent      = 0;
    bodies_sent     = 0;
    settings_used   = 0;
    cur_key         = SearchKeyRst;
    cur_len         = KeyLengthRst;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset key "ssid": found, empty value ended by body_last
    push_str("ssid=");
    send_body(1'b0);

    settle();
    apply_setting(0);
    // Blank-led escape, negative escape wrapping, '+', a 0xff byte, '&' taken
    // as escape data, and a bare '%' at body end
    body_q.delete();
    push_str("a=% 9%-f+");
    body_q.push_back(8'hFF);
    push_str("%&1%");
    send_body(1'b0);
    // Key matched after '&'; escape cut after one byte
    body_q.delete();
    push_str("b&a=%F");
    send_body(1'b0);
    // Not found at the zero byte; body_last after it gives nothing
    body_q.delete();
    body_q.push_back(8'h01);
    body_q.push_back(BodyEnd);
    body_q.push_back(8'h7F);
    send_body(1'b0);

    // Random phases, each under its own register setting
    p = 1;
    while (bytes_sent < TargetItems) begin
      settle();
      apply_setting(p);
      budget = bytes_sent + $urandom_range(25, 50);
      while (bytes_sent < budget) begin
        build_body();
        send_body($urandom_range(0, 3) == 0);
      end
      if (p == 2) begin
        // Back-pressure: long value sent back to back while the receiver holds
        body_q.delete();
        for (int i = 0; i < cur_len; i++) body_q.push_back(cur_key[8*i +: 8]);
        body_q.push_back(CharEq);
        repeat (40) body_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
        hold_req = 1'b1;
        send_body(1'b1);
      end
      p++;
    end

    settle();
    $display("Covered %0d body bytes in %0d bodies across %0d register settings,",
             bytes_sent, bodies_sent, settings_used);
    $display("with one long output hold; %0d items checked, key found in %0d, absent in %0d.",
             result_count, found_count, missing_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule
